// ----- rtl/srit_pkg.sv -----
package srit_pkg;

	// command codes
	typedef enum logic {
		CMD_INSERT = 1'b0,
		CMD_READ   = 1'b1
	} cmd_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_BOUNDS = 2'd1,
		ST_FULL   = 2'd2
	} status_t;

	// one command transaction
	typedef struct packed {
		cmd_t        cmd;
		logic [5:0]  position;
		logic [15:0] new_roll;
		logic [15:0] new_mark;
	} item_t;

	// one result transaction
	typedef struct packed {
		status_t     status;
		logic [15:0] roll_out;
		logic [15:0] mark_out;
		logic [5:0]  entry_count;
	} result_t;

	// broadcast from the top level to every cell
	typedef struct packed {
		logic  ins_en;
		item_t item;
	} cell_ctl_t;

endpackage

// ----- rtl/srit_cell.sv -----
module srit_cell #(
	parameter int KEY_WIDTH = 16,
	parameter int CW        = 6,
	parameter int IDX       = 0
) (
	input  logic                  clk,
	input  srit_pkg::cell_ctl_t   ctl,
	input  logic [CW-1:0]         count,
	input  logic                  prev_disp,
	input  logic [15:0]           prev_roll,
	input  logic [KEY_WIDTH-1:0]  prev_mark,
	output logic                  disp,
	output logic [15:0]           roll,
	output logic [KEY_WIDTH-1:0]  mark
);

	localparam int CMPW = (CW > 6) ? CW : 6;

	logic [15:0]          roll_q;
	logic [KEY_WIDTH-1:0] mark_q;
	logic [KEY_WIDTH-1:0] key;
	logic                 valid;
	logic                 pos_le;

	// the new record lands at or below this slot: the held record moves up
	always_comb begin
		key    = KEY_WIDTH'(32'(ctl.item.new_mark));
		valid  = CW'(IDX) < count;
		pos_le = CMPW'(ctl.item.position) <= CMPW'(IDX);
		disp   = !valid || (pos_le && (mark_q >= key)) || (mark_q > key);
	end

	// take the neighbor's record, or the new one where the shift starts
	always_ff @(posedge clk) begin
		if (ctl.ins_en && disp) begin
			if (prev_disp) begin
				roll_q <= prev_roll;
				mark_q <= prev_mark;
			end else begin
				roll_q <= ctl.item.new_roll;
				mark_q <= key;
			end
		end
	end

	assign roll = roll_q;
	assign mark = mark_q;

endmodule

// ----- rtl/sorted_record_insert_table.sv -----
// Channel   Ports                 Direction  Transfer
// command   start, busy, item     in         start high and busy low at a clock edge
// result    done, result          out        done high for one cycle, always taken
//
// Each command is accepted and its result shows with done
// in the next cycle. Busy stays low, so a command may follow every cycle.
// The insert is applied by the row of cells at the accepting clock edge; each cell
// compares its own mark against the new key and shifts by one in parallel.
// Reset clears the record count; cell contents are undefined until written.
// The receiver cannot stall the result port.
module sorted_record_insert_table #(
	parameter int DEPTH     = 32,
	parameter int KEY_WIDTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  srit_pkg::item_t   item,
	output logic              done,
	output srit_pkg::result_t result
);

	localparam int CW   = $clog2(DEPTH + 1);
	localparam int IW   = $clog2(DEPTH);
	localparam int CMPW = (CW > 6) ? CW : 6;

	logic [CW-1:0]        cnt_q;
	logic [CW-1:0]        cnt_next;
	logic                 done_q;
	srit_pkg::result_t    res_q;
	srit_pkg::result_t    res_next;
	srit_pkg::cell_ctl_t  ctl;
	logic                 accept;
	logic [CMPW-1:0]      pos_w;
	logic [CMPW-1:0]      cnt_w;
	logic [IW-1:0]        rd_idx;

	logic                 disp  [DEPTH];
	logic [15:0]          rolls [DEPTH];
	logic [KEY_WIDTH-1:0] marks [DEPTH];

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign pos_w  = CMPW'(item.position);
	assign cnt_w  = CMPW'(cnt_q);
	assign rd_idx = pos_w[IW-1:0];

	// decide status, read data and insert enable
	always_comb begin
		res_next          = '0;
		res_next.status   = srit_pkg::ST_OK;
		ctl.item          = item;
		ctl.ins_en        = 1'b0;
		if (item.cmd == srit_pkg::CMD_READ) begin
			if (pos_w >= cnt_w) begin
				res_next.status = srit_pkg::ST_BOUNDS;
			end else begin
				res_next.roll_out = rolls[rd_idx];
				res_next.mark_out = 16'(32'(marks[rd_idx]));
			end
		end else begin
			if (pos_w > cnt_w) begin
				res_next.status = srit_pkg::ST_BOUNDS;
			end else if (cnt_q == CW'(DEPTH)) begin
				res_next.status = srit_pkg::ST_FULL;
			end else begin
				ctl.ins_en = accept;
			end
		end
		cnt_next             = ctl.ins_en ? cnt_q + CW'(1) : cnt_q;
		res_next.entry_count = 6'(cnt_next);
	end

	// row of cells, each handing its record to the next on insert
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_head
			srit_cell #(.KEY_WIDTH(KEY_WIDTH), .CW(CW), .IDX(i)) u_cell (
				.clk       (clk),
				.ctl       (ctl),
				.count     (cnt_q),
				.prev_disp (1'b0),
				.prev_roll (item.new_roll),
				.prev_mark (KEY_WIDTH'(32'(item.new_mark))),
				.disp      (disp[i]),
				.roll      (rolls[i]),
				.mark      (marks[i])
			);
		end else begin : g_body
			srit_cell #(.KEY_WIDTH(KEY_WIDTH), .CW(CW), .IDX(i)) u_cell (
				.clk       (clk),
				.ctl       (ctl),
				.count     (cnt_q),
				.prev_disp (disp[i-1]),
				.prev_roll (rolls[i-1]),
				.prev_mark (marks[i-1]),
				.disp      (disp[i]),
				.roll      (rolls[i]),
				.mark      (marks[i])
			);
		end
	end

	// hold the record count and the strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			cnt_q  <= cnt_next;
			done_q <= accept;
		end
	end

	// register the result transaction
	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res_next;
		end
	end

	assign done   = done_q;
	assign result = res_q;

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("record count above capacity");

	a_done_follows_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start))
		else $error("result without a command");

	a_insert_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == srit_pkg::ST_OK &&
			$past(item.cmd) == srit_pkg::CMD_INSERT) |-> cnt_q == $past(cnt_q) + CW'(1))
		else $error("insert did not add one record");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status != srit_pkg::ST_OK) |->
			(result.roll_out == 16'd0 && result.mark_out == 16'd0 && $stable(cnt_q)))
		else $error("failed command changed state or returned data");
`endif

endmodule

// ----- test/sorted_record_insert_table_tb.sv -----
module sorted_record_insert_table_tb;

	localparam int DEPTH        = 32;
	localparam int KEY_WIDTH    = 16;
	localparam logic [15:0] KEY_MASK = 16'((33'd1 << KEY_WIDTH) - 1);
	localparam int RANDOM_ITEMS = 1730;
	localparam int MAX_REPORTS  = 10;

	typedef struct {
		srit_pkg::item_t cmd_item;
		int              wait_cycles;
	} queued_cmd_t;

	logic              clk    = 1'b0;
	logic              arst_n = 1'b0;
	logic              start  = 1'b0;
	logic              busy;
	srit_pkg::item_t   item   = '0;
	logic              done;
	srit_pkg::result_t result;

	// commands waiting to be driven, results waiting to be seen
	queued_cmd_t       cmd_queue[$];
	srit_pkg::result_t expected_results[$];

	// shadow of the table contents
	logic [15:0] shadow_roll [DEPTH];
	logic [15:0] shadow_mark [DEPTH];
	int          shadow_count = 0;

	// count as the generator sees it, used to aim positions
	int gen_count = 0;
	int gen_total = 0;

	queued_cmd_t cur_cmd;
	logic        have_cur  = 1'b0;
	int          idle_left = 0;
	logic        taken     = 1'b0;
	int          fail_count = 0;

	sorted_record_insert_table #(
		.DEPTH(DEPTH),
		.KEY_WIDTH(KEY_WIDTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.done(done),
		.result(result)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// hold reset at the start, then release it on a falling edge
	initial begin
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
	end

	// apply one command to the shadow table and return its result
	function automatic srit_pkg::result_t apply_command(srit_pkg::item_t it);
		srit_pkg::result_t r;
		logic [15:0]       key;
		int                lo;
		int                hi;
		int                at;
		int                i;
		r = '0;
		key = it.new_mark & KEY_MASK;
		if (it.cmd == srit_pkg::CMD_READ) begin
			if (it.position >= shadow_count) begin
				r.status = srit_pkg::ST_BOUNDS;
			end else begin
				r.status   = srit_pkg::ST_OK;
				r.roll_out = shadow_roll[it.position];
				r.mark_out = shadow_mark[it.position];
			end
		end else if (it.position > shadow_count) begin
			r.status = srit_pkg::ST_BOUNDS;
		end else if (shadow_count >= DEPTH) begin
			r.status = srit_pkg::ST_FULL;
		end else begin
			// clamp the position into the run of equal marks
			lo = 0;
			while (lo < shadow_count && shadow_mark[lo] < key)
				lo++;
			hi = lo;
			while (hi < shadow_count && shadow_mark[hi] == key)
				hi++;
			at = it.position;
			if (at < lo)
				at = lo;
			if (at > hi)
				at = hi;
			for (i = shadow_count; i > at; i--) begin
				shadow_roll[i] = shadow_roll[i - 1];
				shadow_mark[i] = shadow_mark[i - 1];
			end
			shadow_roll[at] = it.new_roll;
			shadow_mark[at] = key;
			shadow_count++;
			r.status = srit_pkg::ST_OK;
		end
		r.entry_count = 6'(shadow_count);
		return r;
	endfunction

	// queue one command with its idle gap; gaps vanish in every third stretch
	task automatic queue_cmd(input srit_pkg::cmd_t c, input int pos,
		input logic [15:0] roll, input logic [15:0] mark);
		queued_cmd_t q;
		q.cmd_item.cmd      = c;
		q.cmd_item.position = 6'(pos);
		q.cmd_item.new_roll = roll;
		q.cmd_item.new_mark = mark;
		q.wait_cycles = ((gen_total / 48) % 3 == 0) ? 0 : $urandom_range(0, 11);
		if (c == srit_pkg::CMD_INSERT && pos <= gen_count && gen_count < DEPTH)
			gen_count++;
		gen_total++;
		cmd_queue.push_back(q);
	endtask

	// build the stimulus, then wait for the run to drain
	initial begin : run
		int          n;
		int          pos;
		logic [15:0] roll;
		logic [15:0] mark;

		// empty table, past the end, position zero, equal marks, extremes
		queue_cmd(srit_pkg::CMD_READ,   0, 16'h0000, 16'h0000);
		queue_cmd(srit_pkg::CMD_INSERT, 1, 16'hffff, 16'hffff);
		queue_cmd(srit_pkg::CMD_INSERT, 0, 16'h0000, 16'h8000);
		queue_cmd(srit_pkg::CMD_READ,   0, 16'hffff, 16'hffff);
		queue_cmd(srit_pkg::CMD_INSERT, 0, 16'hffff, 16'hffff);
		queue_cmd(srit_pkg::CMD_INSERT, 2, 16'h1234, 16'h0000);
		queue_cmd(srit_pkg::CMD_INSERT, 3, 16'h0001, 16'h8000);
		queue_cmd(srit_pkg::CMD_INSERT, 0, 16'h0002, 16'h8000);
		queue_cmd(srit_pkg::CMD_INSERT, 2, 16'h0003, 16'h8000);
		queue_cmd(srit_pkg::CMD_INSERT, 6, 16'haaaa, 16'h0000);
		queue_cmd(srit_pkg::CMD_INSERT, 8, 16'h5555, 16'h0001);
		queue_cmd(srit_pkg::CMD_INSERT, 7, 16'h5555, 16'hffff);
		queue_cmd(srit_pkg::CMD_READ,   8, 16'h0000, 16'h0000);
		queue_cmd(srit_pkg::CMD_READ,   7, 16'h0000, 16'h0000);
		queue_cmd(srit_pkg::CMD_READ,   DEPTH, 16'h0000, 16'h0000);
		queue_cmd(srit_pkg::CMD_READ,   2, 16'h0000, 16'h0000);
		queue_cmd(srit_pkg::CMD_READ,   0, 16'h0000, 16'h0000);
		queue_cmd(srit_pkg::CMD_INSERT, 3, 16'hffff, 16'h7fff);

		// random mix; marks come from a small pool often, to force ties
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			case ($urandom_range(0, 3))
				0: mark = 16'($urandom);
				1: mark = 16'(100 * $urandom_range(1, 3));
				2: mark = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
				default: mark = 16'($urandom_range(0, 7));
			endcase
			roll = 16'($urandom);
			if (gen_count < DEPTH ? ($urandom_range(0, 11) == 0)
				: ($urandom_range(0, 3) == 0)) begin
				if (gen_count < DEPTH && $urandom_range(0, 9) == 0)
					pos = $urandom_range(gen_count + 1, DEPTH);
				else
					pos = $urandom_range(0, gen_count);
				queue_cmd(srit_pkg::CMD_INSERT, pos, roll, mark);
			end else begin
				if (gen_count == 0 || $urandom_range(0, 7) == 0)
					pos = $urandom_range(0, DEPTH);
				else
					pos = $urandom_range(0, gen_count - 1);
				queue_cmd(srit_pkg::CMD_READ, pos, roll, mark);
			end
		end

		@(posedge arst_n);
		while (cmd_queue.size() > 0 || have_cur || start)
			@(posedge clk);
		while (expected_results.size() > 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("sorted_record_insert_table_tb: PASS");
		else
			$display("sorted_record_insert_table_tb: FAIL");
		$finish;
	end

	// drive transactions on the falling edge; hold until accepted
	always @(negedge clk) begin : driver
		if (arst_n && !(start && !taken)) begin
			if (!have_cur && cmd_queue.size() > 0) begin
				cur_cmd   = cmd_queue.pop_front();
				idle_left = cur_cmd.wait_cycles;
				have_cur  = 1'b1;
			end
			if (have_cur && idle_left == 0) begin
				start   <= 1'b1;
				item    <= cur_cmd.cmd_item;
				have_cur = 1'b0;
			end else begin
				if (have_cur)
					idle_left--;
				start <= 1'b0;
				item  <= srit_pkg::item_t'({$urandom, $urandom});
			end
		end
	end

	// check results, then predict for the transaction accepted at this edge
	always @(posedge clk) begin : monitor
		srit_pkg::result_t want;
		if (!arst_n) begin
			taken <= 1'b0;
		end else begin
			if (done) begin
				if (expected_results.size() == 0) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("unexpected result: status %0d roll %h mark %h count %0d",
							result.status, result.roll_out, result.mark_out,
							result.entry_count);
				end else begin
					want = expected_results.pop_front();
					if (result.status !== want.status || result.roll_out !== want.roll_out
						|| result.mark_out !== want.mark_out
						|| result.entry_count !== want.entry_count) begin
						fail_count++;
						if (fail_count <= MAX_REPORTS)
							$display({"result mismatch: expected status %0d roll %h mark %h",
								" count %0d, got status %0d roll %h mark %h count %0d"},
								want.status, want.roll_out, want.mark_out, want.entry_count,
								result.status, result.roll_out, result.mark_out,
								result.entry_count);
					end
				end
			end
			if (start && !busy)
				expected_results.push_back(apply_command(item));
			taken <= start && !busy;
		end
	end

	// end a hung run
	initial begin
		#4000000;
		$display("sorted_record_insert_table_tb: FAIL");
		$finish;
	end

endmodule
